FILE: src/i2a_pkg.sv
package i2a_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZERO,
      ST_STRIP,
      ST_PREFIX,
      ST_SIGN,
      ST_DABBLE,
      ST_DSTRIP,
      ST_EMIT
   } state_type;

   // conversion modes
   typedef enum logic [1:0] {
      MODE_BIN,
      MODE_HEX,
      MODE_DEC
   } mode_type;

   // radix codes
   localparam logic [7:0] RADIX_BIN = 8'd2;
   localparam logic [7:0] RADIX_HEX = 8'd16;

   // characters
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ALPHA = 8'h41;

   // widths and counts
   localparam int VALUE_W    = 64;
   localparam int DIGITS     = 20;
   localparam int BCD_W      = 4 * DIGITS;
   localparam int CNT_W      = 7;
   localparam logic [CNT_W-1:0] BIN_UNITS  = 7'd64;
   localparam logic [CNT_W-1:0] HEX_UNITS  = 7'd16;
   localparam logic [CNT_W-1:0] DEC_SHIFTS = 7'd64;
   localparam logic [CNT_W-1:0] DEC_DIGITS = 7'd20;

   // control from the sequencer to the BCD register
   typedef struct packed {
      logic clear;
      logic dabble;
      logic bit_in;
      logic digit_shift;
   } bcd_ctrl_type;

   // upper-case hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {4'b0000, nib};
      end else begin
         c = CHAR_ALPHA + {4'b0000, nib} - 8'd10;
      end
      return c;
   endfunction

endpackage

FILE: src/i2a_bcd.sv
// BCD register: shift-and-add-3 conversion one bit per cycle, then
// digit read-out from the top, one digit per shift.
module i2a_bcd (
   input  logic                   clock,
   input  i2a_pkg::bcd_ctrl_type  ctrl,
   output logic [3:0]             top_digit
);

   logic [i2a_pkg::BCD_W-1:0] bcd_ff;
   logic [i2a_pkg::BCD_W-1:0] bcd_in;
   logic [i2a_pkg::BCD_W-1:0] adj;

   // add 3 to every digit of 5 or more before the doubling shift
   always_comb begin
      for (int i = 0; i < i2a_pkg::DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // next register value
   always_comb begin
      bcd_in = bcd_ff;
      if (ctrl.clear) begin
         bcd_in = '0;
      end else if (ctrl.dabble) begin
         bcd_in = {adj[i2a_pkg::BCD_W-2:0], ctrl.bit_in};
      end else if (ctrl.digit_shift) begin
         bcd_in = {bcd_ff[i2a_pkg::BCD_W-5:0], 4'b0000};
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[i2a_pkg::BCD_W-1 -: 4];

endmodule

FILE: src/int64_to_ascii_radix_unit.sv
// Converts a signed 64-bit word to ASCII text, one character per output word,
// most significant first, with rsp_last_char on the final one. Radix 2 gives
// binary, 16 upper-case hex, anything else signed decimal; zero is always "0".
// One value is handled at a time and req_ready is high only while idle.
// Binary and hex walk a 64-bit shift register: a strip state drops one
// leading zero bit (binary) or byte (hex) per cycle until the first kept
// one is seen, then a prefix state sends a single '0' if binary bits were
// stripped, or "00" if hex bytes were stripped and the first kept byte has
// its top bit set, then one character per cycle while rsp_ready allows.
// Decimal runs a shift-and-add-3 BCD converter: a sign state sends '-' for
// a negative value, one magnitude bit is shifted in per cycle, then leading
// zero digits are stripped one per cycle and the digits sent one per cycle
// while rsp_ready allows. A character that rsp_ready holds off stalls the
// sequence. The output register lets the last character wait for rsp_ready
// while the next value is taken.
module int64_to_ascii_radix_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [63:0] req_value,
   input  logic        [7:0]  req_radix,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [7:0]  rsp_out_char,
   output logic               rsp_last_char
);

   i2a_pkg::state_type             state_ff, state_in;
   i2a_pkg::mode_type              mode_ff, mode_in;
   logic [i2a_pkg::VALUE_W-1:0]    shift_ff, shift_in;
   logic [i2a_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [1:0]                     pre_ff, pre_in;
   logic                           neg_ff, neg_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     rsp_char_ff, rsp_char_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           accept;
   logic                           out_free;
   logic                           push_req;
   logic                           push_fire;
   logic [7:0]                     push_char;
   logic                           push_last;
   logic                           strip_more;
   i2a_pkg::bcd_ctrl_type          bcd_ctrl;
   logic [3:0]                     top_digit;

   i2a_bcd u_bcd (
      .clock     (clock),
      .ctrl      (bcd_ctrl),
      .top_digit (top_digit)
   );

   assign req_ready = (state_ff == i2a_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign push_fire = push_req && out_free;

   // another leading zero bit (binary) or byte (hex) to drop
   assign strip_more = (mode_ff == i2a_pkg::MODE_BIN) ? !shift_ff[63]
                                                      : (shift_ff[63:56] == 8'h00);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         i2a_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_value == 64'sd0) begin
                  state_in = i2a_pkg::ST_ZERO;
               end else if (req_radix == i2a_pkg::RADIX_BIN ||
                            req_radix == i2a_pkg::RADIX_HEX) begin
                  state_in = i2a_pkg::ST_STRIP;
               end else begin
                  state_in = i2a_pkg::ST_SIGN;
               end
            end
         end
         i2a_pkg::ST_ZERO: begin
            if (push_fire) state_in = i2a_pkg::ST_IDLE;
         end
         i2a_pkg::ST_STRIP: begin
            if (!strip_more) state_in = i2a_pkg::ST_PREFIX;
         end
         i2a_pkg::ST_PREFIX: begin
            if (pre_ff == 2'd0) state_in = i2a_pkg::ST_EMIT;
         end
         i2a_pkg::ST_SIGN: begin
            if (!neg_ff || push_fire) state_in = i2a_pkg::ST_DABBLE;
         end
         i2a_pkg::ST_DABBLE: begin
            if (cnt_ff == 7'd1) state_in = i2a_pkg::ST_DSTRIP;
         end
         i2a_pkg::ST_DSTRIP: begin
            if (top_digit != 4'd0) state_in = i2a_pkg::ST_EMIT;
         end
         i2a_pkg::ST_EMIT: begin
            if (push_fire && cnt_ff == 7'd1) state_in = i2a_pkg::ST_IDLE;
         end
         default: begin
            state_in = i2a_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and character generation
   always_comb begin
      mode_in   = mode_ff;
      shift_in  = shift_ff;
      cnt_in    = cnt_ff;
      pre_in    = pre_ff;
      neg_in    = neg_ff;
      push_req  = 1'b0;
      push_char = i2a_pkg::CHAR_ZERO;
      push_last = 1'b0;
      bcd_ctrl  = '0;
      case (state_ff)
         i2a_pkg::ST_IDLE: begin
            if (accept) begin
               neg_in   = req_value[63];
               shift_in = req_value;
               if (req_radix == i2a_pkg::RADIX_BIN) begin
                  mode_in = i2a_pkg::MODE_BIN;
                  cnt_in  = i2a_pkg::BIN_UNITS;
               end else if (req_radix == i2a_pkg::RADIX_HEX) begin
                  mode_in = i2a_pkg::MODE_HEX;
                  cnt_in  = i2a_pkg::HEX_UNITS;
               end else begin
                  mode_in = i2a_pkg::MODE_DEC;
                  cnt_in  = i2a_pkg::DEC_SHIFTS;
                  // magnitude; the most negative value maps onto itself
                  if (req_value[63]) shift_in = ~req_value + 64'd1;
               end
            end
         end
         i2a_pkg::ST_ZERO: begin
            push_req  = 1'b1;
            push_last = 1'b1;
         end
         i2a_pkg::ST_STRIP: begin
            if (strip_more) begin
               if (mode_ff == i2a_pkg::MODE_BIN) begin
                  shift_in = {shift_ff[62:0], 1'b0};
                  cnt_in   = cnt_ff - 7'd1;
               end else begin
                  shift_in = {shift_ff[55:0], 8'h00};
                  cnt_in   = cnt_ff - 7'd2;
               end
            end else if (mode_ff == i2a_pkg::MODE_BIN) begin
               pre_in = (cnt_ff != i2a_pkg::BIN_UNITS) ? 2'd1 : 2'd0;
            end else begin
               pre_in = (cnt_ff != i2a_pkg::HEX_UNITS && shift_ff[63]) ? 2'd2 : 2'd0;
            end
         end
         i2a_pkg::ST_PREFIX: begin
            push_req = (pre_ff != 2'd0);
            if (push_fire) pre_in = pre_ff - 2'd1;
         end
         i2a_pkg::ST_SIGN: begin
            bcd_ctrl.clear = 1'b1;
            push_req       = neg_ff;
            push_char      = i2a_pkg::CHAR_MINUS;
         end
         i2a_pkg::ST_DABBLE: begin
            bcd_ctrl.dabble = 1'b1;
            bcd_ctrl.bit_in = shift_ff[63];
            shift_in        = {shift_ff[62:0], 1'b0};
            cnt_in          = (cnt_ff == 7'd1) ? i2a_pkg::DEC_DIGITS : cnt_ff - 7'd1;
         end
         i2a_pkg::ST_DSTRIP: begin
            if (top_digit == 4'd0) begin
               bcd_ctrl.digit_shift = 1'b1;
               cnt_in               = cnt_ff - 7'd1;
            end
         end
         i2a_pkg::ST_EMIT: begin
            push_req  = 1'b1;
            push_last = (cnt_ff == 7'd1);
            case (mode_ff)
               i2a_pkg::MODE_BIN: begin
                  push_char = shift_ff[63] ? i2a_pkg::CHAR_ONE : i2a_pkg::CHAR_ZERO;
               end
               i2a_pkg::MODE_HEX: begin
                  push_char = i2a_pkg::hex_char(shift_ff[63:60]);
               end
               default: begin
                  push_char = i2a_pkg::CHAR_ZERO + {4'b0000, top_digit};
               end
            endcase
            if (push_fire) begin
               cnt_in = cnt_ff - 7'd1;
               case (mode_ff)
                  i2a_pkg::MODE_BIN: shift_in = {shift_ff[62:0], 1'b0};
                  i2a_pkg::MODE_HEX: shift_in = {shift_ff[59:0], 4'h0};
                  default:           bcd_ctrl.digit_shift = 1'b1;
               endcase
            end
         end
         default: begin
            push_req = 1'b0;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (push_fire) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = push_char;
         rsp_last_in  = push_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2a_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      shift_ff    <= shift_in;
      cnt_ff      <= cnt_in;
      pre_ff      <= pre_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

FILE: verif/int64_to_ascii_radix_unit_test.sv
`timescale 1ns / 1ps

module int64_to_ascii_radix_unit_test;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 320;
   localparam int DRAIN_CYCLES   = 120;
   localparam int RANDOM_VALUES  = 346;
   localparam int CALM_FROM      = 306;
   localparam logic [127:0] HEX_GLYPHS = "0123456789ABCDEF";

   // one expected output word
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_word_type;

   // expected characters and the checks made against them
   class char_scoreboard;
      text_word_type text_queue[$];
      int errors;
      int n_values;
      int n_chars;
      int n_bin;
      int n_hex;
      int n_dec;

      function logic [7:0] hex_glyph(input logic [3:0] nib);
         return HEX_GLYPHS[8 * (15 - nib) +: 8];
      endfunction

      function void push_char(input logic [7:0] ch);
         text_word_type w;
         w.ch   = ch;
         w.last = 1'b0;
         text_queue.push_back(w);
      endfunction

      // work out the text for one accepted value
      function void note_value(input logic [63:0] value, input logic [7:0] radix);
         logic [63:0] n;
         logic [63:0] mag;
         logic [7:0]  digits[$];
         int          i;
         n = value;
         n_values++;
         if (n == 64'd0) begin
            push_char(i2a_pkg::CHAR_ZERO);
         end else if (radix == i2a_pkg::RADIX_BIN) begin
            n_bin++;
            i = 0;
            while (i < 64 && !n[63]) begin
               n = n << 1;
               i++;
            end
            // a stripped zero leaves one '0' so the text never looks signed
            if (i != 0) push_char(i2a_pkg::CHAR_ZERO);
            while (i < 64) begin
               push_char(n[63] ? i2a_pkg::CHAR_ONE : i2a_pkg::CHAR_ZERO);
               n = n << 1;
               i++;
            end
         end else if (radix == i2a_pkg::RADIX_HEX) begin
            n_hex++;
            i = 0;
            while (i < 8 && n[63:56] == 8'h00) begin
               n = n << 8;
               i++;
            end
            if (i != 0 && n[63]) begin
               push_char(i2a_pkg::CHAR_ZERO);
               push_char(i2a_pkg::CHAR_ZERO);
            end
            while (i < 8) begin
               push_char(hex_glyph(n[63:60]));
               push_char(hex_glyph(n[59:56]));
               n = n << 8;
               i++;
            end
         end else begin
            n_dec++;
            mag = n;
            if (n[63]) begin
               push_char(i2a_pkg::CHAR_MINUS);
               mag = ~n + 64'd1;
            end
            while (mag != 64'd0) begin
               digits.push_front(i2a_pkg::CHAR_ZERO + 8'(mag % 64'd10));
               mag = mag / 64'd10;
            end
            foreach (digits[k]) push_char(digits[k]);
         end
         text_queue[text_queue.size() - 1].last = 1'b1;
      endfunction

      function void report(input string what);
         errors++;
         if (errors <= 10) $display("[%0t] MISMATCH: %s", $realtime, what);
      endfunction

      // compare one accepted output word with the oldest expectation
      function void check_char(input logic [7:0] ch, input logic last);
         text_word_type w;
         n_chars++;
         if (text_queue.size() == 0) begin
            report($sformatf("unexpected word char=%h last=%b", ch, last));
         end else begin
            w = text_queue.pop_front();
            if (w.ch !== ch || w.last !== last)
               report($sformatf("expected char=%h last=%b, got char=%h last=%b",
                                w.ch, w.last, ch, last));
         end
      endfunction

      function int pending();
         return text_queue.size();
      endfunction

      function void final_check();
         if (text_queue.size() != 0)
            report($sformatf("%0d expected words never arrived", text_queue.size()));
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [63:0] req_value;
   logic        [7:0]  req_radix;
   logic               rsp_valid;
   logic               rsp_ready;
   logic        [7:0]  rsp_out_char;
   logic               rsp_last_char;

   char_scoreboard board;
   bit             calm;
   bit             hold_request;
   bit             hold_active;
   int             quiet_cycles;

   int64_to_ascii_radix_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_radix     (req_radix),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_value    = '0;
      req_radix    = '0;
      rsp_ready    = 1'b0;
      calm         = 1'b0;
      hold_request = 1'b0;
      hold_active  = 1'b0;
      quiet_cycles = 0;
      board        = new();
   end

   always #5 clock = ~clock;

   // offer one value and wait for it to be taken
   task automatic send_value(input logic [63:0] value, input logic [7:0] radix);
      req_valid <= 1'b1;
      req_value <= value;
      req_radix <= radix;
      do @(posedge clock); while (!req_ready);
      board.note_value(value, radix);
   endtask

   // random gap on the input side
   task automatic maybe_idle_input();
      if (!calm && !hold_active && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   function automatic logic [63:0] random_value();
      logic [63:0] r;
      int          k;
      r = {$urandom, $urandom};
      k = $urandom_range(0, 63);
      case ($urandom_range(0, 6))
         0: random_value = r;
         1: random_value = r >> k;
         2: random_value = 64'($urandom_range(0, 300));
         3: random_value = -64'($urandom_range(1, 300));
         4: random_value = (64'd1 << k) - 64'($urandom_range(0, 1));
         5: random_value = (r | 64'h8000000000000000) >> (8 * $urandom_range(0, 7));
         default: random_value = -(r >> k);
      endcase
   endfunction

   function automatic logic [7:0] random_radix();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) random_radix = i2a_pkg::RADIX_BIN;
      else if (pick < 65) random_radix = i2a_pkg::RADIX_HEX;
      else if (pick < 85) random_radix = 8'd10;
      else random_radix = 8'($urandom_range(0, 255));
   endfunction

   // input side: directed values, then random ones
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // zero in every radix, then extremes and prefix cases
      send_value(64'd0, i2a_pkg::RADIX_BIN);
      send_value(64'd0, i2a_pkg::RADIX_HEX);
      send_value(64'd0, 8'd10);
      send_value(64'd1, i2a_pkg::RADIX_BIN);
      send_value(64'hFFFFFFFFFFFFFFFF, i2a_pkg::RADIX_BIN);
      send_value(64'h8000000000000000, i2a_pkg::RADIX_BIN);
      send_value(64'h7FFFFFFFFFFFFFFF, i2a_pkg::RADIX_BIN);
      send_value(64'h8000000000000000, i2a_pkg::RADIX_HEX);
      send_value(64'h7FFFFFFFFFFFFFFF, i2a_pkg::RADIX_HEX);
      send_value(64'h0000000000000080, i2a_pkg::RADIX_HEX);
      send_value(64'h000000000000007F, i2a_pkg::RADIX_HEX);
      send_value(64'h0000000000800000, i2a_pkg::RADIX_HEX);
      send_value(64'h00FF00000000ABCD, i2a_pkg::RADIX_HEX);
      send_value(64'hFFFFFFFFFFFFFFFF, i2a_pkg::RADIX_HEX);
      send_value(64'h8000000000000000, 8'd10);
      send_value(64'h7FFFFFFFFFFFFFFF, 8'd10);
      send_value(64'hFFFFFFFFFFFFFFFF, 8'd10);
      send_value(64'd12345, 8'd10);
      send_value(64'd9, 8'd0);
      send_value(-64'd1000, 8'd255);
      send_value(64'd10, 8'd3);
      send_value(64'd255, 8'd17);
      send_value(64'd4, 8'd1);
      send_value(64'h0123456789ABCDEF, 8'd18);

      for (int k = 0; k < RANDOM_VALUES; k++) begin
         calm = (k >= CALM_FROM);
         if (k == 120) hold_request = 1'b1;
         if (k == 240) begin
            // let the block drain completely before carrying on
            req_valid <= 1'b0;
            @(posedge clock);
            while (board.pending() != 0) @(posedge clock);
         end
         maybe_idle_input();
         send_value(random_value(), random_radix());
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.final_check();
      $display("Converted %0d values (%0d binary, %0d hex, %0d decimal, rest zero), %0d chars.",
               board.n_values, board.n_bin, board.n_hex, board.n_dec, board.n_chars);
      $display("Included extremes, prefix cases, odd radix codes, a long output stall.");
      if (board.errors == 0) begin
         $display("int64_to_ascii_radix_unit regression: pass");
      end else begin
         $display("int64_to_ascii_radix_unit regression: fail");
      end
      $finish;
   end

   // output side: random back-pressure and one long hold-off
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_active  = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ready <= 1'b1;
            hold_active = 1'b0;
         end else if (!calm && $urandom_range(0, 99) < 12) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // check every output word taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_char(rsp_out_char, rsp_last_char);
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no progress, %0d words still expected",
                     $realtime, board.pending());
            $display("int64_to_ascii_radix_unit regression: fail");
            $finish;
         end
      end
   end

endmodule
